>>> src/enc_pd_pkg.sv
// ----------------------------------------------------------------------------
// enc_pd_pkg
// shared widths, register indexes and reset values of the encoder pd controller
// ----------------------------------------------------------------------------
package enc_pd_pkg;

  // fractional bits of the q-format gains
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int COUNT_W  = 16;
  localparam int POS_W    = 32;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 15;
  localparam int CMP_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P           = 3'd0,
    REG_GAIN_D           = 3'd1,
    REG_INVERT_ENCODER   = 3'd2,
    REG_INVERT_DIRECTION = 3'd3,
    REG_CONTROL_LIMIT    = 3'd4,
    REG_COMPARE_LIMIT    = 3'd5,
    REG_DEADBAND         = 3'd6,
    REG_MIN_DRIVE        = 3'd7
  } reg_idx_t;

  // reset values
  localparam logic [GAIN_W-1:0]  GAIN_P_RST        = 16'd256;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST        = 16'd0;
  localparam logic [LIMIT_W-1:0] CONTROL_LIMIT_RST = 15'd1000;
  localparam logic [CMP_W-1:0]   COMPARE_LIMIT_RST = 16'd999;
  localparam logic [CMP_W-1:0]   DEADBAND_RST      = 16'd3;
  localparam logic [LIMIT_W-1:0] MIN_DRIVE_RST     = 15'd80;

endpackage

>>> src/enc_pd_sample_if.sv
// ----------------------------------------------------------------------------
// enc_pd_sample_if
// input channel: encoder counter and target position for one control tick
// ----------------------------------------------------------------------------
interface enc_pd_sample_if import enc_pd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [COUNT_W-1:0]      raw_count;
  logic signed [POS_W-1:0] target_position;

  modport source (output valid, raw_count, target_position, input ready);
  modport sink   (input valid, raw_count, target_position, output ready);
endinterface

>>> src/enc_pd_result_if.sv
// ----------------------------------------------------------------------------
// enc_pd_result_if
// output channel: direction, pwm compare value, settled flag and position
// ----------------------------------------------------------------------------
interface enc_pd_result_if import enc_pd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    direction;
  logic [CMP_W-1:0]        compare_value;
  logic                    settled;
  logic signed [POS_W-1:0] position;

  modport source (output valid, direction, compare_value, settled, position, input ready);
  modport sink   (input valid, direction, compare_value, settled, position, output ready);
endinterface

>>> src/enc_pd_cfg_if.sv
// ----------------------------------------------------------------------------
// enc_pd_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface enc_pd_cfg_if import enc_pd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/encoder_position_pd_controller.sv
// ----------------------------------------------------------------------------
// encoder_position_pd_controller
// pd position loop on a wrapping quadrature counter, with deadband, kick and clamps
// ----------------------------------------------------------------------------
// usage
//   sample : one word per control tick, the raw 16-bit counter and the target
//   result : one word per sample, direction pin level, pwm compare value,
//            settled flag and the accumulated position after that tick
//   cfg    : register writes, always ready; write only while no word is in flight
// timing
//   a three-stage pipeline: stage one integrates the counter delta and forms
//   error and derivative (this loop on the position and previous error is what
//   sets the one-word-per-cycle rate), stage two holds the two gain products
//   and the deadband test, stage three sums, kicks, clamps and registers the
//   result. result valid rises once the word has passed the stage one, two and
//   three registers; one word per cycle is sustained while result.ready is high.
// stalls
//   each stage advances when the one after it is empty or moving, so bubbles
//   are squeezed out and new words are taken while a finished result waits.
//   with all stages full and the receiver stalling, sample.ready drops.
// reset
//   rst (synchronous) empties the pipeline, clears counter, position and
//   previous error, and loads the register reset values
// ----------------------------------------------------------------------------
module encoder_position_pd_controller import enc_pd_pkg::*; #(
  parameter int GainFracBits = GAIN_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  enc_pd_cfg_if.sink        cfg,
  enc_pd_sample_if.sink     sample,
  enc_pd_result_if.source   result
);

  localparam int ProdW  = GAIN_W + POS_W;   // one gain product
  localparam int AccW   = ProdW + 1;        // sum of both products
  localparam int ErrMagW = POS_W + 1;       // exact magnitude of the error

  // configuration registers
  logic signed [GAIN_W-1:0] gain_p;
  logic signed [GAIN_W-1:0] gain_d;
  logic                     invert_encoder;
  logic                     invert_direction;
  logic [LIMIT_W-1:0]       control_limit;
  logic [CMP_W-1:0]         compare_limit;
  logic [CMP_W-1:0]         deadband;
  logic [LIMIT_W-1:0]       min_drive;

  // loop state
  logic [COUNT_W-1:0]      last_count;
  logic signed [POS_W-1:0] position_acc;
  logic signed [POS_W-1:0] previous_error;

  // pipeline control
  logic v1, v2, v3;
  logic en1, en2, en3;
  logic accept;

  // stage one
  logic signed [POS_W-1:0] err1, der1, pos1;
  // stage two
  logic signed [ProdW-1:0] prod_p, prod_d;
  logic                    settled2;
  logic signed [POS_W-1:0] pos2;
  // stage three, the result register
  logic                    direction;
  logic [CMP_W-1:0]        compare_value;
  logic                    settled3;
  logic signed [POS_W-1:0] pos3;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p           <= GAIN_P_RST;
      gain_d           <= GAIN_D_RST;
      invert_encoder   <= 1'b0;
      invert_direction <= 1'b0;
      control_limit    <= CONTROL_LIMIT_RST;
      compare_limit    <= COMPARE_LIMIT_RST;
      deadband         <= DEADBAND_RST;
      min_drive        <= MIN_DRIVE_RST;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_GAIN_P:           gain_p           <= cfg.data;
        REG_GAIN_D:           gain_d           <= cfg.data;
        REG_INVERT_ENCODER:   invert_encoder   <= cfg.data[0];
        REG_INVERT_DIRECTION: invert_direction <= cfg.data[0];
        REG_CONTROL_LIMIT:    control_limit    <= cfg.data[LIMIT_W-1:0];
        REG_COMPARE_LIMIT:    compare_limit    <= cfg.data;
        REG_DEADBAND:         deadband         <= cfg.data;
        REG_MIN_DRIVE:        min_drive        <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // handshake: a stage takes a new word when it is empty or passing its own on
  assign en3    = !v3 || result.ready;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;
  assign accept = sample.valid && en1;

  assign sample.ready = en1;

  // stage one: wrapped counter delta into the position, then error and derivative
  logic [COUNT_W-1:0]      delta_raw, delta;
  logic signed [POS_W-1:0] pos_next, err_next, der_next;

  always_comb begin
    delta_raw = sample.raw_count - last_count;
    // negation wraps in 16 bits, so the most negative delta stays as it is
    delta     = invert_encoder ? (COUNT_W'(0) - delta_raw) : delta_raw;
    pos_next  = position_acc + {{(POS_W-COUNT_W){delta[COUNT_W-1]}}, delta};
    err_next  = sample.target_position - pos_next;
    der_next  = err_next - previous_error;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count     <= '0;
      position_acc   <= '0;
      previous_error <= '0;
      v1             <= 1'b0;
    end else begin
      if (en1) v1 <= accept;
      if (accept) begin
        last_count     <= sample.raw_count;
        position_acc   <= pos_next;
        previous_error <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err1 <= err_next;
      der1 <= der_next;
      pos1 <= pos_next;
    end
  end

  // stage two: gain products and the deadband test on the exact |error|
  logic [ErrMagW-1:0] err_ext, err_mag;

  always_comb begin
    err_ext = {err1[POS_W-1], err1};
    err_mag = err1[POS_W-1] ? (ErrMagW'(0) - err_ext) : err_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && en2) begin
      prod_p   <= ProdW'(gain_p) * ProdW'(err1);
      prod_d   <= ProdW'(gain_d) * ProdW'(der1);
      settled2 <= err_mag <= ErrMagW'(deadband);
      pos2     <= pos1;
    end
  end

  // stage three: sum, kick floor, drive clamp, truncation, compare clamp
  logic signed [AccW-1:0] acc;
  logic [AccW-1:0]        acc_mag, kick, lim, mag_kicked, mag_clamped;
  logic [LIMIT_W-1:0]     drive_mag;
  logic                   drive_neg;
  logic                   dir_next;
  logic [CMP_W-1:0]       cmp_next;

  always_comb begin
    acc     = AccW'(prod_p) + AccW'(prod_d);
    acc_mag = acc[AccW-1] ? (AccW'(0) - acc) : acc;
    kick    = AccW'(min_drive) << GainFracBits;
    lim     = AccW'(control_limit) << GainFracBits;
    // kick and clamp act on the magnitude alike for both signs
    mag_kicked  = (acc_mag != '0 && acc_mag < kick) ? kick : acc_mag;
    mag_clamped = (mag_kicked > lim) ? lim : mag_kicked;
    // truncation toward zero drops the fraction of the magnitude
    drive_mag   = LIMIT_W'(mag_clamped >> GainFracBits);
    drive_neg   = acc[AccW-1] && (drive_mag != '0);
    if (settled2) begin
      dir_next = !invert_direction;
      cmp_next = '0;
    end else begin
      dir_next = (!drive_neg) ^ invert_direction;
      cmp_next = (CMP_W'(drive_mag) > compare_limit) ? compare_limit : CMP_W'(drive_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && en3) begin
      direction     <= dir_next;
      compare_value <= cmp_next;
      settled3      <= settled2;
      pos3          <= pos2;
    end
  end

  assign result.valid         = v3;
  assign result.direction     = direction;
  assign result.compare_value = compare_value;
  assign result.settled       = settled3;
  assign result.position      = pos3;

`ifndef NO_ASSERTIONS
  // a settled tick drives nothing
  a_settled_zero: assert property (@(posedge clk) disable iff (rst)
    v3 && settled3 |-> compare_value == '0 && direction == !invert_direction)
    else $error("settled result with nonzero drive");

  // the compare value never exceeds its limit
  a_cmp_limit: assert property (@(posedge clk) disable iff (rst)
    v3 |-> compare_value <= compare_limit)
    else $error("compare value above compare limit");

  // an accepted word always lands in stage one
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted word lost at stage one");

  // a stalled result keeps the pipeline behind it from overrunning it
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !result.ready |=> v3 && $stable(pos3) && $stable(compare_value))
    else $error("stalled result overwritten");
`endif

endmodule

>>> test/encoder_position_pd_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_position_pd_controller_test
// Self-checking bench for the encoder pd controller. A predictor in the bench
// follows the counter delta, the position, the error history and the register
// image, and works out the word that each tick should give. Each result word
// is checked field by field against the oldest prediction. The bench runs
// directed ticks around the deadband, kick, clamp and wrap corners. It then
// runs random register phases with random gaps on both sides, an output
// hold-off that fills the pipeline, and a run of half-turn counter steps.
// ----------------------------------------------------------------------------
module encoder_position_pd_controller_test;
  import enc_pd_pkg::*;

  localparam int RANDOM_PHASES   = 6;
  localparam int TICKS_PER_PHASE = 300;
  localparam int SETTLE_CYCLES   = 8;      // pipeline is three deep, with margin
  localparam int HOLD_OFF_CYCLES = 48;
  localparam int MAX_REPORTS     = 50;
  localparam int WRAP_TICKS      = 64;     // half-turn steps, back to back

  // full register image, one 16-bit write word per register index
  typedef logic [7:0][CFG_DATA_W-1:0] reg_image_t;

  // one result word as the block should produce it
  typedef struct packed {
    logic             direction;
    logic [CMP_W-1:0] compare_value;
    logic             settled;
    logic [POS_W-1:0] position;
  } drive_word_t;

  logic clk = 1'b0;
  logic rst;

  enc_pd_cfg_if    cfg_ch ();
  enc_pd_sample_if sample_ch ();
  enc_pd_result_if result_ch ();

  encoder_position_pd_controller i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (sample_ch),
    .result (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // controller mirror: register copies and loop state
  // --------------------------------------------------------------------------
  logic signed [GAIN_W-1:0] kp, kd;
  logic                     inv_enc, inv_dir;
  logic [LIMIT_W-1:0]       ctrl_lim, min_drv;
  logic [CMP_W-1:0]         cmp_lim, dband;

  logic [COUNT_W-1:0] enc_last;
  logic [POS_W-1:0]   pos_acc;
  logic [POS_W-1:0]   err_prev;

  drive_word_t drive_outputs_due[$];

  int  mismatch_count = 0;
  bit  tx_idling = 1'b0;
  bit  rx_idling = 1'b0;
  int  rx_hold_cycles = 0;

  // one control tick: integrate the counter, form error and derivative, then
  // deadband, gains, kick floor and the two clamps
  function automatic drive_word_t pd_control_step(logic [COUNT_W-1:0] raw,
                                                  logic [POS_W-1:0] target);
    logic [COUNT_W-1:0] step;
    logic [POS_W-1:0]   e, d;
    longint             err, der, mag, acc, kick, lim, drv;
    drive_word_t        w;
    step = raw - enc_last;
    enc_last = raw;
    if (inv_enc) step = -step;          // -32768 stays -32768 in 16 bits
    pos_acc = pos_acc + {{(POS_W-COUNT_W){step[COUNT_W-1]}}, step};
    e = target - pos_acc;
    d = e - err_prev;
    err_prev = e;
    err = $signed(e);
    der = $signed(d);
    mag = (err < 0) ? -err : err;       // exact, so -2^31 never falls inside
    w.settled = (mag <= longint'(dband));
    if (w.settled) begin
      drv = 0;
    end else begin
      acc  = longint'(kp) * err + longint'(kd) * der;
      kick = longint'(min_drv) <<< GAIN_FRAC_BITS_DEF;
      lim  = longint'(ctrl_lim) <<< GAIN_FRAC_BITS_DEF;
      if (acc > 0 && acc < kick) acc = kick;
      if (acc < 0 && acc > -kick) acc = -kick;
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      drv = acc / (longint'(1) <<< GAIN_FRAC_BITS_DEF);   // truncates toward zero
    end
    w.direction = (drv >= 0) ^ inv_dir;
    mag = (drv < 0) ? -drv : drv;
    if (mag > longint'(cmp_lim)) mag = longint'(cmp_lim);
    w.compare_value = mag[CMP_W-1:0];
    w.position = pos_acc;
    return w;
  endfunction

  function automatic reg_image_t reset_image();
    reg_image_t img;
    img = '0;
    img[REG_GAIN_P]        = GAIN_P_RST;
    img[REG_GAIN_D]        = GAIN_D_RST;
    img[REG_CONTROL_LIMIT] = {1'b0, CONTROL_LIMIT_RST};
    img[REG_COMPARE_LIMIT] = COMPARE_LIMIT_RST;
    img[REG_DEADBAND]      = DEADBAND_RST;
    img[REG_MIN_DRIVE]     = {1'b0, MIN_DRIVE_RST};
    return img;
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 3))
      0:       return GAIN_W'($urandom);
      1:       return GAIN_W'($urandom_range(1, 1024));
      2:       return -GAIN_W'($urandom_range(1, 1024));
      default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  // mostly moderate limits so that kick, clamp and settle all occur;
  // full-width words now and then, spare bits included
  function automatic reg_image_t random_settings();
    reg_image_t img;
    img[REG_GAIN_P]           = random_gain();
    img[REG_GAIN_D]           = random_gain();
    img[REG_INVERT_ENCODER]   = CFG_DATA_W'($urandom);
    img[REG_INVERT_DIRECTION] = CFG_DATA_W'($urandom);
    img[REG_CONTROL_LIMIT]    = $urandom_range(0, 2) == 0 ? CFG_DATA_W'($urandom)
                                                         : CFG_DATA_W'($urandom_range(0, 2000));
    img[REG_COMPARE_LIMIT]    = $urandom_range(0, 2) == 0 ? CFG_DATA_W'($urandom)
                                                         : CFG_DATA_W'($urandom_range(0, 1500));
    img[REG_DEADBAND]         = $urandom_range(0, 3) == 0 ? CFG_DATA_W'($urandom)
                                                         : CFG_DATA_W'($urandom_range(0, 20));
    img[REG_MIN_DRIVE]        = $urandom_range(0, 3) == 0 ? CFG_DATA_W'($urandom)
                                                         : CFG_DATA_W'($urandom_range(0, 200));
    return img;
  endfunction

  // --------------------------------------------------------------------------
  // channel drivers
  // --------------------------------------------------------------------------

  // writes all eight registers back to back, mirror follows each accepted write
  task automatic load_settings(reg_image_t img);
    reg_idx_t idx;
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= img[idx];
      do @(posedge clk); while (!cfg_ch.ready);
      case (idx)
        REG_GAIN_P:           kp       = img[idx];
        REG_GAIN_D:           kd       = img[idx];
        REG_INVERT_ENCODER:   inv_enc  = img[idx][0];
        REG_INVERT_DIRECTION: inv_dir  = img[idx][0];
        REG_CONTROL_LIMIT:    ctrl_lim = img[idx][LIMIT_W-1:0];
        REG_COMPARE_LIMIT:    cmp_lim  = img[idx];
        REG_DEADBAND:         dband    = img[idx];
        REG_MIN_DRIVE:        min_drv  = img[idx][LIMIT_W-1:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // offers one tick word, with an optional gap first; valid is left high so
  // that a following word goes out on the next cycle
  task automatic send_tick(logic [COUNT_W-1:0] raw, logic [POS_W-1:0] target);
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    sample_ch.valid           <= 1'b1;
    sample_ch.raw_count       <= raw;
    sample_ch.target_position <= target;
    do @(posedge clk); while (!sample_ch.ready);
    drive_outputs_due.push_back(pd_control_step(raw, target));
  endtask

  // drops valid, lets every predicted word come out, then a short pause
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    while (drive_outputs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly small counter steps and targets near the new position, so the
  // deadband edge, kick and clamps are all hit; some pure noise words too
  task automatic run_random_ticks(int count);
    logic [COUNT_W-1:0] raw, step;
    logic [POS_W-1:0]   pos_next, target;
    int                 off;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        raw    = COUNT_W'($urandom);
        target = $urandom;
      end else begin
        if ($urandom_range(0, 7) == 0) raw = COUNT_W'($urandom);
        else raw = enc_last + COUNT_W'($urandom_range(0, 600)) - 16'd300;
        step = raw - enc_last;
        if (inv_enc) step = -step;
        pos_next = pos_acc + {{(POS_W-COUNT_W){step[COUNT_W-1]}}, step};
        case ($urandom_range(0, 3))
          0:       off = int'($urandom_range(0, 2 * int'(dband) + 2)) - int'(dband) - 1;
          1:       off = int'($urandom_range(0, 4000)) - 2000;
          2:       off = int'($urandom_range(0, 200000)) - 100000;
          default: off = $urandom;
        endcase
        target = pos_next + POS_W'(off);
      end
      send_tick(raw, target);
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: ready pattern and checking
  // --------------------------------------------------------------------------

  // random stall bursts, ready runs, and a counted hold-off on request
  initial begin : result_receiver
    result_ch.ready = 1'b0;
    forever begin
      if (rx_hold_cycles != 0) begin
        result_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else if (rx_idling && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : check_results
    drive_word_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (drive_outputs_due.size() == 0) begin
        report_mismatch("result word with no tick outstanding");
      end else begin
        want = drive_outputs_due.pop_front();
        if (result_ch.direction !== want.direction)
          report_mismatch($sformatf("direction %b, want %b",
                                    result_ch.direction, want.direction));
        if (result_ch.compare_value !== want.compare_value)
          report_mismatch($sformatf("compare_value %0d, want %0d",
                                    result_ch.compare_value, want.compare_value));
        if (result_ch.settled !== want.settled)
          report_mismatch($sformatf("settled %b, want %b",
                                    result_ch.settled, want.settled));
        if (result_ch.position !== want.position)
          report_mismatch($sformatf("position %0d, want %0d",
                                    result_ch.position, $signed(want.position)));
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset register values: on target, just outside the deadband both ways
  // (kicked to the floor), a large error through both clamps, counter wrap
  task automatic test_reset_defaults();
    send_tick(enc_last, pos_acc);
    send_tick(enc_last, pos_acc + 32'd4);
    send_tick(enc_last, pos_acc - 32'd4);
    send_tick(enc_last, pos_acc + 32'd2000);
    send_tick(16'hffff, pos_acc);          // counter steps back through zero
    wait_idle();
  endtask

  // negated counter deltas, including the half-turn step that cannot be
  // negated, and an inverted direction pin; spare data bits set
  task automatic test_encoder_inversion();
    reg_image_t img;
    img = reset_image();
    img[REG_INVERT_ENCODER]   = 16'hffff;
    img[REG_INVERT_DIRECTION] = 16'h8001;
    load_settings(img);
    send_tick(enc_last ^ 16'h8000, pos_acc);
    send_tick(enc_last + 16'd1, pos_acc - 32'd1000);
    send_tick(enc_last - 16'd5, pos_acc);
    send_tick(enc_last, pos_acc - 32'd5);  // lands just outside the deadband
    wait_idle();
  endtask

  // extreme gains and full-width limits: deadband edges at the top of its
  // range, the most negative error, and a derivative that overflows
  task automatic test_extremes();
    reg_image_t img;
    img = reset_image();
    img[REG_GAIN_P]        = 16'h8000;
    img[REG_GAIN_D]        = 16'h7fff;
    img[REG_CONTROL_LIMIT] = 16'hffff;
    img[REG_COMPARE_LIMIT] = 16'hffff;
    img[REG_DEADBAND]      = 16'hffff;
    img[REG_MIN_DRIVE]     = 16'hffff;
    load_settings(img);
    send_tick(enc_last, pos_acc + 32'd65535);
    send_tick(enc_last, pos_acc - 32'd65535);
    send_tick(enc_last, pos_acc + 32'd65536);
    send_tick(enc_last, pos_acc + 32'h4000_0000);
    send_tick(enc_last, pos_acc + 32'h8000_0000);  // error -2^31, derivative wraps
    send_tick(enc_last, pos_acc + 32'h7fff_ffff);
    wait_idle();
  endtask

  // fraction-only drive with no floor, kick floor above the control limit,
  // zero compare limit, zero control limit with opposed extreme gains
  task automatic test_kick_and_fraction();
    reg_image_t img;
    img = reset_image();
    img[REG_GAIN_P]    = 16'd1;
    img[REG_MIN_DRIVE] = 16'd0;
    load_settings(img);
    send_tick(enc_last, pos_acc + 32'd4);
    send_tick(enc_last, pos_acc - 32'd4);
    wait_idle();

    img[REG_MIN_DRIVE]     = 16'd500;
    img[REG_CONTROL_LIMIT] = 16'd100;
    img[REG_COMPARE_LIMIT] = 16'd0;
    img[REG_DEADBAND]      = 16'd0;
    load_settings(img);
    send_tick(enc_last, pos_acc + 32'd1);
    send_tick(enc_last, pos_acc - 32'd1);
    wait_idle();

    img[REG_GAIN_P]        = 16'h7fff;
    img[REG_GAIN_D]        = 16'h8000;
    img[REG_CONTROL_LIMIT] = 16'd0;
    img[REG_COMPARE_LIMIT] = 16'd999;
    img[REG_MIN_DRIVE]     = 16'd0;
    load_settings(img);
    send_tick(enc_last, pos_acc + 32'd1);
    send_tick(enc_last, pos_acc - 32'd3);
    wait_idle();
  endtask

  // receiver holds off for a long stretch while ticks keep coming, so the
  // pipeline fills and the sample side has to stall
  task automatic test_output_backpressure();
    load_settings(random_settings());
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    rx_hold_cycles = HOLD_OFF_CYCLES;
    run_random_ticks(60);
    wait_idle();
  endtask

  // random register phases; the last one runs with no gaps at all
  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_settings(random_settings());
      tx_idling = (p != RANDOM_PHASES - 1);
      rx_idling = (p != RANDOM_PHASES - 1);
      run_random_ticks(TICKS_PER_PHASE);
      wait_idle();
    end
  endtask

  // half-turn counter steps under inversion walk the position down by 32768
  // per tick, with random targets and no gaps
  task automatic test_position_wrap();
    reg_image_t img;
    img = random_settings();
    img[REG_INVERT_ENCODER] = 16'h0001;
    load_settings(img);
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    for (int i = 0; i < WRAP_TICKS; i++) send_tick(enc_last ^ 16'h8000, $urandom);
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // run
  // --------------------------------------------------------------------------
  initial begin : run
    rst                       = 1'b1;
    cfg_ch.valid              = 1'b0;
    cfg_ch.index              = REG_GAIN_P;
    cfg_ch.data               = '0;
    sample_ch.valid           = 1'b0;
    sample_ch.raw_count       = '0;
    sample_ch.target_position = '0;

    // mirror starts from the reset state of the block
    kp = GAIN_P_RST;
    kd = GAIN_D_RST;
    inv_enc  = 1'b0;
    inv_dir  = 1'b0;
    ctrl_lim = CONTROL_LIMIT_RST;
    cmp_lim  = COMPARE_LIMIT_RST;
    dband    = DEADBAND_RST;
    min_drv  = MIN_DRIVE_RST;
    enc_last = '0;
    pos_acc  = '0;
    err_prev = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_encoder_inversion();
    test_extremes();
    test_kick_and_fraction();
    test_output_backpressure();
    test_random_phases();
    test_position_wrap();

    if (mismatch_count == 0) begin
      $display("encoder_position_pd_controller_test: PASS");
    end else begin
      $display("encoder_position_pd_controller_test: FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin : watchdog
    #10_000_000;
    $display("encoder_position_pd_controller_test: FAIL");
    $finish;
  end

endmodule
